>>> rtl/esc_pkg.sv
// Shared types, constants and a helper function of the JSON string escaper.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] CAP_RESET  = 16'hFFFF;
	localparam logic [7:0]  CTRL_LIMIT = 8'h20;
	localparam logic [7:0]  CH_BSLASH  = 8'h5C;
	localparam logic [7:0]  CH_QUOTE   = 8'h22;
	localparam logic [7:0]  CH_U       = 8'h75;
	localparam logic [7:0]  CH_ZERO    = 8'h30;
	localparam logic [7:0]  HEX_ALPHA  = 8'h57;

	localparam logic [1:0] KIND_PASS  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_UNI   = 2'd2;

	typedef struct packed {
		logic        ovf;
		logic [1:0]  kind;
		logic [7:0]  ch;
		logic        str_end;
		logic [15:0] base;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic [2:0] esc_len(input logic ovf, input logic [1:0] kind);
		logic [2:0] n;
		n = 3'd1;
		if (!ovf) begin
			case (kind)
				KIND_SHORT: n = 3'd2;
				KIND_UNI:   n = 3'd6;
				default:    n = 3'd1;
			endcase
		end
		return n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/esc_if.sv
// Valid/ready channel interfaces for raw input bytes and escaped output bytes.
`timescale 1ns / 1ps
`default_nettype none
interface esc_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_start;
	logic       string_end;

	modport source (output valid, output in_byte, output string_start, output string_end,
		input ready);
	modport sink (input valid, input in_byte, input string_start, input string_end,
		output ready);
endinterface

interface esc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        string_done;
	logic        overflow;
	logic [15:0] written_count;

	modport source (output valid, output out_byte, output run_last, output string_done,
		output overflow, output written_count, input ready);
	modport sink (input valid, input out_byte, input run_last, input string_done,
		input overflow, input written_count, output ready);
endinterface
`default_nettype wire

>>> rtl/esc_front.sv
// Front end: accepts raw bytes, classifies them, checks capacity and queues jobs.
`timescale 1ns / 1ps
`default_nettype none
module esc_front #(
	parameter int COUNT_WIDTH = esc_pkg::COUNT_WIDTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	esc_raw_if.sink             raw,
	input  wire                 cfg_we,
	input  wire  [15:0]         cfg_wdata,
	input  esc_pkg::q_stat_t    q_stat,
	output logic                push,
	output esc_pkg::job_t       job
);

	localparam int W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   ovf_q;
	logic [15:0]            cap_q;

	logic [COUNT_WIDTH-1:0] cnt_eff;
	logic                   ovf_eff;
	logic [1:0]             kind;
	logic [7:0]             ch;
	logic [2:0]             len;
	logic [W-1:0]           sum;
	logic [W-1:0]           cap_x;
	logic [W-1:0]           lim;
	logic [W-1:0]           cap_eff;
	logic                   no_fit;
	logic                   accept;

	function automatic logic [1:0] KIND_SHORT_OR_PASS(input logic [7:0] c);
		logic [1:0] k;
		case (c) inside
			esc_pkg::CH_QUOTE, esc_pkg::CH_BSLASH, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09:
				k = esc_pkg::KIND_SHORT;
			default:
				k = (c < esc_pkg::CTRL_LIMIT) ? esc_pkg::KIND_UNI : esc_pkg::KIND_PASS;
		endcase
		return k;
	endfunction

	assign raw.ready = !q_stat.full;
	assign accept    = raw.valid && raw.ready;
	assign cnt_eff   = raw.string_start ? '0 : cnt_q;
	assign ovf_eff   = raw.string_start ? 1'b0 : ovf_q;

	always_comb begin
		kind = KIND_SHORT_OR_PASS(raw.in_byte);
		ch   = raw.in_byte;
		unique case (raw.in_byte)
			esc_pkg::CH_QUOTE:  ch = esc_pkg::CH_QUOTE;
			esc_pkg::CH_BSLASH: ch = esc_pkg::CH_BSLASH;
			8'h08:              ch = 8'h62;
			8'h0C:              ch = 8'h66;
			8'h0A:              ch = 8'h6E;
			8'h0D:              ch = 8'h72;
			8'h09:              ch = 8'h74;
			default:            ch = raw.in_byte;
		endcase
	end

	assign len     = esc_pkg::esc_len(1'b0, kind);
	assign sum     = W'(cnt_eff) + W'(len);
	assign cap_x   = W'(cap_q);
	assign lim     = W'(1) << COUNT_WIDTH;
	assign cap_eff = (cap_x < lim) ? cap_x : lim;
	assign no_fit  = (sum >= cap_eff);

	always_comb begin
		job.ovf     = ovf_eff || no_fit;
		job.kind    = kind;
		job.ch      = ch;
		job.str_end = raw.string_end;
		job.base    = 16'(cnt_eff);
		push        = accept && (!ovf_eff || raw.string_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			cap_q <= esc_pkg::CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				if (ovf_eff) begin
					cnt_q <= cnt_eff;
					ovf_q <= 1'b1;
				end else if (no_fit) begin
					cnt_q <= cnt_eff;
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= COUNT_WIDTH'(sum);
					ovf_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/esc_queue.sv
// Short first-word-fall-through job queue between the front end and the emitter.
`timescale 1ns / 1ps
`default_nettype none
module esc_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  esc_pkg::job_t      wr_job,
	input  wire                pop,
	output esc_pkg::job_t      rd_job,
	output esc_pkg::q_stat_t   stat
);

	esc_pkg::job_t                   mem [esc_pkg::QUEUE_DEPTH];
	logic [esc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [esc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [esc_pkg::QCNT_W-1:0]      cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == esc_pkg::QCNT_W'(esc_pkg::QUEUE_DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_job     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/esc_back.sv
// Back end: expands queued jobs into escaped bytes, one per cycle unless stalled, into an output register.
`timescale 1ns / 1ps
`default_nettype none
module esc_back (
	input  wire                clk,
	input  wire                arst_n,
	input  esc_pkg::job_t      job,
	input  esc_pkg::q_stat_t   q_stat,
	output logic               pop,
	esc_out_if.source          esc
);

	logic [2:0]  idx_q;
	logic        out_v_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        done_q;
	logic        ovf_q;
	logic [15:0] wcnt_q;

	logic [2:0]  len;
	logic        is_last;
	logic        advance;
	logic [7:0]  nxt_byte;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? (esc_pkg::CH_ZERO + 8'(nib)) : (esc_pkg::HEX_ALPHA + 8'(nib));
	endfunction

	assign len     = esc_pkg::esc_len(job.ovf, job.kind);
	assign is_last = (idx_q == len - 3'd1);
	assign advance = !q_stat.empty && (!out_v_q || esc.ready);
	assign pop     = advance && is_last;

	always_comb begin
		nxt_byte = job.ch;
		if (job.ovf) begin
			nxt_byte = 8'h00;
		end else begin
			case (job.kind)
				esc_pkg::KIND_SHORT: begin
					nxt_byte = (idx_q == 3'd0) ? esc_pkg::CH_BSLASH : job.ch;
				end
				esc_pkg::KIND_UNI: begin
					case (idx_q)
						3'd0:    nxt_byte = esc_pkg::CH_BSLASH;
						3'd1:    nxt_byte = esc_pkg::CH_U;
						3'd2:    nxt_byte = esc_pkg::CH_ZERO;
						3'd3:    nxt_byte = esc_pkg::CH_ZERO;
						3'd4:    nxt_byte = hex_char(job.ch[7:4]);
						default: nxt_byte = hex_char(job.ch[3:0]);
					endcase
				end
				default: nxt_byte = job.ch;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= nxt_byte;
			last_q <= is_last;
			done_q <= is_last && job.str_end;
			ovf_q  <= job.ovf;
			wcnt_q <= job.ovf ? job.base : job.base + 16'(idx_q) + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (advance) begin
				out_v_q <= 1'b1;
				idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
			end else if (esc.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign esc.valid         = out_v_q;
	assign esc.out_byte      = byte_q;
	assign esc.run_last      = last_q;
	assign esc.string_done   = done_q;
	assign esc.overflow      = ovf_q;
	assign esc.written_count = wcnt_q;

endmodule
`default_nettype wire

>>> rtl/json_string_escaper_top.sv
// Top level of the JSON string escaper: front end, job queue and byte emitter.
//
// Usage: raw string bytes enter on the raw channel (valid/ready, one byte per
// transfer, with string_start and string_end marks). Escaped bytes leave on the
// esc channel, one byte per transfer, with run_last on the final byte of each
// input byte's expansion and string_done on the final byte of a string.
// A byte that would not fit the capacity gives one overflow result, and later
// bytes of that string give nothing until its end byte, which again gives one.
// The capacity register is written through cfg_we/cfg_wdata; the user must do so only while idle (not enforced).
// A raw transfer's job passes through the job queue and then the output register before its first escaped byte.
// Throughput is one output byte per cycle while jobs are queued and the receiver is ready, set
// by the single emitter; a plain byte gives one output byte, a short escape two and a \u00xx escape six.
// A four-entry job queue lets raw transfers continue while the emitter works.
// When the receiver stalls, the output register holds its byte, the queue
// fills and raw.ready falls once it is full.
// Reset clears the count, the overflow flag and the queue and sets the
// capacity to 65535.
`timescale 1ns / 1ps
`default_nettype none
module json_string_escaper_top #(
	parameter int COUNT_WIDTH = esc_pkg::COUNT_WIDTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	esc_raw_if.sink      raw,
	esc_out_if.source    esc,
	input  wire          cfg_we,
	input  wire  [15:0]  cfg_wdata
);

	logic               push;
	logic               pop;
	esc_pkg::job_t      wr_job;
	esc_pkg::job_t      rd_job;
	esc_pkg::q_stat_t   q_stat;

	esc_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.push      (push),
		.job       (wr_job)
	);

	esc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.stat   (q_stat)
	);

	esc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (rd_job),
		.q_stat (q_stat),
		.pop    (pop),
		.esc    (esc)
	);

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		esc.valid && esc.overflow |-> esc.out_byte == 8'h00 && esc.run_last)
		else $error("Overflow result carries data or is not the last of its run.");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		esc.valid && esc.string_done |-> esc.run_last)
		else $error("String end flagged before the end of its run.");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("Job queue reports full and empty at once.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("Emitter pops an empty job queue.");

endmodule
`default_nettype wire
